/* hdl/ftbp_pkg.sv */
// shared constants, codes and control types for the token bucket policer
package ftbp_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int IDX_W       = SLOT_W + 1;
  localparam int DIV_STEPS   = 64;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

  // reciprocal of 1e9 / 512: RQ_M = floor(2^53 / RQ_D)
  localparam logic [20:0] RQ_D = 21'h1D_CD65;
  localparam logic [32:0] RQ_M = 33'h1_12E0_BE82;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BURST = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 8'd1;

  typedef enum logic [2:0] {
    OUT_KNOWN_PASS  = 3'd0,
    OUT_KNOWN_DROP  = 3'd1,
    OUT_NEW_ADMIT   = 3'd2,
    OUT_NEW_OVERSZ  = 3'd3,
    OUT_TABLE_FULL  = 3'd4
  } outcome_t;

  typedef enum logic {
    DIV_SPAN = 1'b0,
    DIV_FULL = 1'b1
  } div_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     span_mul;
    logic     limit;
    logic     scan_start;
    logic     scan;
    logic     diff;
    logic     cmp;
    logic     mul;
    logic     sum;
    logic     rq_mul;
    logic     rq_est;
    logic     rq_rem;
    logic     rq_fix;
    logic     token;
    logic     finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic hit;
    logic refill_ok;
    logic out_free;
  } sts_t;

endpackage

/* hdl/ftbp_div.sv */
// serial restoring divider, one quotient bit per cycle
module ftbp_div import ftbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [63:0]       q;
  logic [32:0]       trial;
  logic [32:0]       diff;
  logic              take;

  // one restoring step
  always_comb begin
    trial = {rem, q[63]};
    diff  = trial - {1'b0, dvs};
    take  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? diff[31:0] : trial[31:0];
      q   <= {q[62:0], take};
    end
  end

  assign quotient = q;

endmodule

/* hdl/ftbp_dp.sv */
// datapath: config registers, flow table, slot scan, refill arithmetic, result register
module ftbp_dp import ftbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [111:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] tokens;
    logic [62:0] stamp;
  } entry_t;

  logic [31:0] burst;
  logic [31:0] rate;
  logic [31:0] rate_eff;

  logic [31:0] key;
  logic [15:0] size;
  logic [62:0] now;

  entry_t mem [TABLE_SLOTS];
  entry_t rd_q;
  logic              we;
  logic [SLOT_W-1:0] wa;
  entry_t            wd;

  logic [TABLE_SLOTS-1:0] valid;

  logic [IDX_W-1:0]  scan_idx;
  logic              pv;
  logic [SLOT_W-1:0] pidx;
  logic              hit_f;
  logic [SLOT_W-1:0] hit_idx;
  logic [31:0]       hit_tokens;
  logic [62:0]       hit_stamp;
  logic              free_f;
  logic [SLOT_W-1:0] free_idx;
  logic              cur_v;
  logic              cur_exp;
  logic              cur_live;

  logic [62:0] span;
  logic [62:0] limit;
  logic        noexp;
  logic [62:0] diff;
  logic [61:0] fullnum;
  logic        refill_ok;
  logic [63:0] plo;
  logic [62:0] phi;
  logic [63:0] prod;
  logic [31:0] tok;
  logic [32:0] tok_sum;

  logic [52:0] rq_y;
  logic [64:0] rq_lo;
  logic [53:0] rq_hi;
  logic [85:0] rq_sum;
  logic [31:0] rq_est;
  logic [52:0] rq_back;
  logic [52:0] rq_left;
  logic [21:0] rq_rem;
  logic [31:0] rq_quot;

  logic [63:0] div_a;
  logic        div_done;
  logic [63:0] quot;

  logic        fwd;
  outcome_t    code;
  logic        res_fwd;
  outcome_t    res_code;
  logic        set_valid;

  assign rate_eff = (rate == 32'd0) ? 32'd1 : rate;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= 32'd0;
      rate  <= 32'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BURST: burst <= cfg_data;
        REG_RATE:  rate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key  <= s_tdata[31:0];
      size <= s_tdata[47:32];
      now  <= s_tdata[110:48];
    end
  end

  // shared divider dividend select, divisor is always the rate (a zero rate is taken as one)
  always_comb begin
    unique case (cmd.div_sel)
      DIV_FULL: div_a = {2'd0, fullnum};
      default:  div_a = {32'd0, burst};
    endcase
  end

  ftbp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (rate_eff),
    .done     (div_done),
    .quotient (quot)
  );

  // span, expiry limit, elapsed time and refill products
  always_ff @(posedge clk) begin
    if (cmd.span_mul) span <= 63'({32'd0, quot[31:0]} * {34'd0, NS_PER_SEC});
    if (cmd.limit) begin
      noexp <= (now < span);
      limit <= now - span;
    end
    if (cmd.diff) begin
      diff    <= (now >= hit_stamp) ? (now - hit_stamp) : 63'd0;
      fullnum <= {30'd0, burst} * {32'd0, NS_PER_SEC};
    end
    if (cmd.cmp) refill_ok <= ({1'b0, diff} < quot);
    if (cmd.mul) begin
      plo <= {32'd0, diff[31:0]} * {32'd0, rate_eff};
      phi <= {32'd0, diff[62:32]} * {31'd0, rate_eff};
    end
    if (cmd.sum) prod <= plo + {phi[31:0], 32'd0};
    if (cmd.token) tok <= (refill_ok && (tok_sum <= {1'b0, burst})) ? tok_sum[31:0] : burst;
  end

  // refill quotient prod / 1e9 by reciprocal multiplication on prod / 512;
  // the estimate is the quotient or one below it, one compare fixes it
  assign rq_y    = prod[61:9];
  assign rq_sum  = {21'd0, rq_lo} + {rq_hi, 32'd0};
  assign rq_back = {21'd0, rq_est} * {32'd0, RQ_D};
  assign rq_left = rq_y - rq_back;

  always_ff @(posedge clk) begin
    if (cmd.rq_mul) begin
      rq_lo <= {33'd0, rq_y[31:0]} * {32'd0, RQ_M};
      rq_hi <= {33'd0, rq_y[52:32]} * {21'd0, RQ_M};
    end
    if (cmd.rq_est) rq_est <= rq_sum[84:53];
    if (cmd.rq_rem) rq_rem <= rq_left[21:0];
    if (cmd.rq_fix) rq_quot <= rq_est + {31'd0, (rq_rem >= {1'b0, RQ_D})};
  end

  assign tok_sum = {1'b0, hit_tokens} + {1'b0, rq_quot};

  // table memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[scan_idx[SLOT_W-1:0]];
  end

  // per-slot expiry and match on the entry read in the previous cycle
  always_comb begin
    cur_v    = valid[pidx];
    cur_exp  = cur_v && !noexp && (rd_q.stamp < limit);
    cur_live = cur_v && !cur_exp;
  end

  // slot scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pv       <= 1'b0;
      hit_f    <= 1'b0;
      free_f   <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_idx <= '0;
      pv       <= 1'b0;
      hit_f    <= 1'b0;
      free_f   <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_idx != IDX_W'(TABLE_SLOTS)) begin
        scan_idx <= scan_idx + 1'b1;
        pv       <= 1'b1;
      end else begin
        pv <= 1'b0;
      end
      if (pv) begin
        if (cur_live && (rd_q.key == key) && !hit_f) hit_f <= 1'b1;
        if (!cur_live && !free_f) free_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pidx <= scan_idx[SLOT_W-1:0];
      if (pv && cur_live && (rd_q.key == key) && !hit_f) begin
        hit_idx    <= pidx;
        hit_tokens <= rd_q.tokens;
        hit_stamp  <= rd_q.stamp;
      end
      if (pv && !cur_live && !free_f) free_idx <= pidx;
    end
  end

  // decision and table update for the finished item
  always_comb begin
    fwd       = 1'b0;
    code      = OUT_TABLE_FULL;
    we        = 1'b0;
    wa        = hit_idx;
    wd.key    = key;
    wd.stamp  = now;
    wd.tokens = tok;
    set_valid = 1'b0;
    if (hit_f) begin
      we = cmd.finish;
      if (tok > {16'd0, size}) begin
        wd.tokens = tok - {16'd0, size};
        fwd       = 1'b1;
        code      = OUT_KNOWN_PASS;
      end else begin
        code = OUT_KNOWN_DROP;
      end
    end else if ({16'd0, size} > burst) begin
      code = OUT_NEW_OVERSZ;
    end else if (!free_f) begin
      code = OUT_TABLE_FULL;
    end else begin
      we        = cmd.finish;
      wa        = free_idx;
      wd.tokens = burst - {16'd0, size};
      set_valid = cmd.finish;
      fwd       = 1'b1;
      code      = OUT_NEW_ADMIT;
    end
  end

  // slot valid bits: cleared by expiry, set by admission
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.scan && pv && cur_exp) valid[pidx] <= 1'b0;
      if (set_valid) valid[free_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_fwd  <= fwd;
      res_code <= code;
    end
  end

  assign m_tdata = {4'd0, res_code, res_fwd};

  assign sts.div_done  = div_done;
  assign sts.scan_done = cmd.scan && (scan_idx == IDX_W'(TABLE_SLOTS)) && !pv;
  assign sts.hit       = hit_f;
  assign sts.refill_ok = refill_ok;
  assign sts.out_free  = !m_tvalid || m_tready;

endmodule

/* hdl/ftbp_ctrl.sv */
// controller: sequences divider, scan, refill steps and result hand-off
module ftbp_ctrl import ftbp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [17:0] {
    ST_IDLE      = 18'h00001,
    ST_SPAN_GO   = 18'h00002,
    ST_SPAN_WAIT = 18'h00004,
    ST_SPAN_MUL  = 18'h00008,
    ST_LIMIT     = 18'h00010,
    ST_SCAN      = 18'h00020,
    ST_DIFF      = 18'h00040,
    ST_FULL_GO   = 18'h00080,
    ST_FULL_WAIT = 18'h00100,
    ST_CMP       = 18'h00200,
    ST_MUL       = 18'h00400,
    ST_SUM       = 18'h00800,
    ST_RQ_MUL    = 18'h01000,
    ST_RQ_EST    = 18'h02000,
    ST_RQ_REM    = 18'h04000,
    ST_RQ_FIX    = 18'h08000,
    ST_TOKEN     = 18'h10000,
    ST_FINISH    = 18'h20000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_SPAN;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
        if (s_tvalid) state_next = ST_SPAN_GO;
      end
      ST_SPAN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_SPAN_WAIT;
      end
      ST_SPAN_WAIT: if (sts.div_done) state_next = ST_SPAN_MUL;
      ST_SPAN_MUL: begin
        cmd.span_mul = 1'b1;
        state_next   = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit      = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = sts.hit ? ST_DIFF : ST_FINISH;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_FULL_GO;
      end
      ST_FULL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FULL;
        state_next    = ST_FULL_WAIT;
      end
      ST_FULL_WAIT: if (sts.div_done) state_next = ST_CMP;
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = sts.refill_ok ? ST_SUM : ST_TOKEN;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_RQ_MUL;
      end
      ST_RQ_MUL: begin
        cmd.rq_mul = 1'b1;
        state_next = ST_RQ_EST;
      end
      ST_RQ_EST: begin
        cmd.rq_est = 1'b1;
        state_next = ST_RQ_REM;
      end
      ST_RQ_REM: begin
        cmd.rq_rem = 1'b1;
        state_next = ST_RQ_FIX;
      end
      ST_RQ_FIX: begin
        cmd.rq_fix = 1'b1;
        state_next = ST_TOKEN;
      end
      ST_TOKEN: begin
        cmd.token  = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/per_flow_token_bucket_policer.sv */
// per-flow token bucket policer top level
// throughput: one packet at a time; the controller is idle and ready for the next one as the
//   result enters the output register; the time a packet takes is set by the 64-step serial
//   divider (used once or twice) and the one-slot-per-cycle table scan; a held result stalls it
// reset: table empty, burst 0, rate 1, controller idle, no result pending
module per_flow_token_bucket_policer import ftbp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [111:0]         s_tdata,   // dest_addr[31:0], pkt_size[47:32], now_ns[110:48]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // forward[0], outcome[3:1]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ftbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ftbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

  // a result never appears the cycle after an input transaction
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result appeared right after input transaction");

  // forward flag agrees with the outcome code
  a_fwd_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == ((m_tdata[3:1] == OUT_KNOWN_PASS) ||
                                 (m_tdata[3:1] == OUT_NEW_ADMIT))))
    else $error("forward flag disagrees with outcome");

  // input is not taken while the datapath finishes a packet
  a_no_accept_on_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !s_tready)
    else $error("input ready while finishing a packet");

endmodule

/* tb/sv/per_flow_token_bucket_policer_tb.sv */
// testbench for the per-flow token bucket policer, self-checking against its own flow table model
module per_flow_token_bucket_policer_tb;
  import ftbp_pkg::*;

  localparam longint unsigned NS_SEC = 64'd1000000000;
  localparam longint unsigned TIME_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    bit       forward;
    outcome_t outcome;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [111:0]         s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // policer model state
  bit [31:0]       burst_q;
  bit [31:0]       rate_q;
  bit              flow_live[TABLE_SLOTS];
  bit [31:0]       flow_key[TABLE_SLOTS];
  bit [31:0]       flow_tokens[TABLE_SLOTS];
  longint unsigned flow_stamp[TABLE_SLOTS];

  verdict_t verdict_q[$];
  int       mismatches;
  int       rx_hold;
  bit       quiet;
  longint unsigned clock_ns;

  per_flow_token_bucket_policer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // expected verdict of one packet, updating the flow table
  function automatic verdict_t police(bit [31:0] addr, bit [15:0] size, longint unsigned now);
    longint unsigned rate;
    longint unsigned burst;
    longint unsigned span;
    longint unsigned elapsed;
    longint unsigned tok;
    int hit;
    int vacant;
    verdict_t v;
    rate = (rate_q == 0) ? 64'd1 : 64'(rate_q);
    burst = 64'(burst_q);
    hit = -1;
    vacant = -1;
    v.forward = 1'b0;
    // age out stale flows unless the clock is still inside the span
    span = NS_SEC * (burst / rate);
    if (now >= span) begin
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (flow_live[i] && flow_stamp[i] < now - span) flow_live[i] = 1'b0;
    end
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (flow_live[i]) begin
        if (hit < 0 && flow_key[i] == addr) hit = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end
    if (hit >= 0) begin
      elapsed = (now >= flow_stamp[hit]) ? now - flow_stamp[hit] : 64'd0;
      if (elapsed < burst * NS_SEC / rate) begin
        tok = 64'(flow_tokens[hit]) + elapsed * rate / NS_SEC;
        if (tok > burst) tok = burst;
      end else begin
        tok = burst;
      end
      flow_stamp[hit] = now;
      if (tok > 64'(size)) begin
        tok -= 64'(size);
        v.forward = 1'b1;
        v.outcome = OUT_KNOWN_PASS;
      end else begin
        v.outcome = OUT_KNOWN_DROP;
      end
      flow_tokens[hit] = tok[31:0];
    end else if (64'(size) > burst) begin
      v.outcome = OUT_NEW_OVERSZ;
    end else if (vacant < 0) begin
      v.outcome = OUT_TABLE_FULL;
    end else begin
      flow_live[vacant] = 1'b1;
      flow_key[vacant] = addr;
      flow_tokens[vacant] = burst_q - 32'(size);
      flow_stamp[vacant] = now;
      v.forward = 1'b1;
      v.outcome = OUT_NEW_ADMIT;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("error: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // one packet transaction on the input stream
  task automatic send_pkt(bit [31:0] addr, bit [15:0] size, longint unsigned now);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, now[62:0], size, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    verdict_q.push_back(police(addr, size, now & TIME_MASK));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_BURST) burst_q = value;
    else if (idx == REG_RATE) rate_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result, m_tdata", m_tdata, 0);
      end else begin
        verdict_t want;
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.forward) report_mismatch("forward", m_tdata[0], want.forward);
        if (m_tdata[3:1] !== want.outcome)
          report_mismatch("outcome", m_tdata[3:1], want.outcome);
        if (m_tdata[7:4] !== 4'd0) report_mismatch("padding", m_tdata[7:4], 0);
      end
      rx_hold = quiet ? 0 : $urandom_range(0, 15);
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // reset values: zero burst admits only empty packets
  task automatic test_defaults();
    send_pkt(32'h0000_0000, 16'd0, 64'd0);
    send_pkt(32'h0000_0000, 16'd0, 64'd5);
    send_pkt(32'hFFFF_FFFF, 16'hFFFF, 64'd10);
    send_pkt(32'hFFFF_FFFF, 16'd1, 64'd10);
  endtask

  // register writes: ignored indexes, zero rate, lowered burst, clock going back
  task automatic test_registers();
    write_reg(8'd2, 32'd12345);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    write_reg(REG_BURST, 32'd4000);
    write_reg(REG_RATE, 32'd0);
    send_pkt(32'h0A00_0001, 16'd1000, 64'd100);
    send_pkt(32'h0A00_0001, 16'd2999, 64'd200);
    send_pkt(32'h0A00_0001, 16'd1, 64'd50);
    send_pkt(32'h0A00_0002, 16'd4000, 64'd300);
    send_pkt(32'h0A00_0003, 16'd4001, 64'd300);
    write_reg(REG_RATE, 32'd1000);
    send_pkt(32'h0A00_0001, 16'd500, 64'd2_000_000_000);
    write_reg(REG_BURST, 32'd800);
    send_pkt(32'h0A00_0002, 16'd10, 64'd2_100_000_000);
    send_pkt(32'h0A00_0001, 16'd799, 64'd9_000_000_000);
  endtask

  // 63-bit time and 32-bit register extremes
  task automatic test_extremes();
    write_reg(REG_BURST, 32'hFFFF_FFFF);
    write_reg(REG_RATE, 32'hFFFF_FFFF);
    send_pkt(32'h5555_AAAA, 16'hFFFF, TIME_MASK - 64'd10);
    send_pkt(32'h5555_AAAA, 16'hFFFF, TIME_MASK);
    send_pkt(32'hAAAA_5555, 16'h8000, TIME_MASK);
    write_reg(REG_RATE, 32'd1);
    send_pkt(32'h1234_5678, 16'h7FFF, 64'h4000_0000_0000_0000);
    send_pkt(32'h1234_5678, 16'hFFFF, 64'h4000_0000_0000_1000);
  endtask

  // fill every slot, overflow, then let a long pause age everything out
  task automatic test_table_full();
    write_reg(REG_BURST, 32'd1000);
    write_reg(REG_RATE, 32'd1);
    clock_ns = 64'd5_000_000_000_000;
    for (int i = 0; i < TABLE_SLOTS + 2; i++)
      send_pkt(32'hC0A8_0000 + i, 16'(i), clock_ns + i);
    send_pkt(32'hC0A8_0000, 16'd1, clock_ns + 100);
    clock_ns += 64'd2_000_000_000_000;
    send_pkt(32'hC0A8_7777, 16'd5, clock_ns);
  endtask

  // flows drawn from a small address pool, clock mostly moving forward
  task automatic run_phase(bit [31:0] burst, bit [31:0] rate, longint unsigned start,
                           int step_max, int pool, int count);
    bit [31:0] base;
    bit [31:0] addr;
    bit [15:0] size;
    int size_max;
    int pick;
    write_reg(REG_BURST, burst);
    write_reg(REG_RATE, rate);
    base = $urandom;
    clock_ns = start;
    size_max = (burst / 3 > 65535) ? 65535 : burst / 3;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      addr = (pick < 90) ? base + $urandom_range(0, pool - 1) : $urandom;
      size = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, size_max));
      pick = $urandom_range(0, 99);
      if (pick < 3) clock_ns -= $urandom_range(0, 1000);
      else if (pick < 6) clock_ns += 64'($urandom) * 64'd4;
      else clock_ns += $urandom_range(0, step_max);
      clock_ns &= TIME_MASK;
      send_pkt(addr, size, clock_ns);
    end
    quiet = 1'b0;
  endtask

  task automatic test_random();
    run_phase(32'd3000, 32'd1000, 64'd0, 200_000_000, 12, 150);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h7000_0000_0000_0000, 1_000_000, 20, 130);
    run_phase(32'd100000, 32'd0, 64'h0100_0000_0000, 1000, 80, 150);
    run_phase($urandom_range(0, 200000), $urandom_range(1, 50000), 64'($urandom) << 20,
              50_000_000, 30, 130);
    run_phase($urandom, $urandom, {1'b0, 31'($urandom), 32'($urandom)} & 64'h3FFF_FFFF_FFFF_FFFF,
              500_000_000, 16, 140);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_q = 32'd0;
    rate_q = 32'd1;
    for (int i = 0; i < TABLE_SLOTS; i++) flow_live[i] = 1'b0;
    mismatches = 0;
    rx_hold = 0;
    quiet = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_registers();
    test_extremes();
    test_table_full();
    test_random();
    wait_idle();
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("per_flow_token_bucket_policer: match");
    else $display("per_flow_token_bucket_policer: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("per_flow_token_bucket_policer: mismatch");
    $finish;
  end

endmodule

/* sim.f */
hdl/ftbp_pkg.sv
hdl/ftbp_div.sv
hdl/ftbp_dp.sv
hdl/ftbp_ctrl.sv
hdl/per_flow_token_bucket_policer.sv
tb/sv/per_flow_token_bucket_policer_tb.sv
